### design/updf_pkg.sv
// Shared types and constants for the update package deframer.
// Holds the result word layout, the byte and status codes and the signature.
// No dependencies.
package updf_pkg;

  localparam int DIGEST_BYTES_DEFAULT = 16;

  localparam int KIND_W   = 3;
  localparam int STATUS_W = 3;
  localparam int LEN_W    = 31;

  // Byte classification codes.
  localparam logic [KIND_W-1:0] KIND_PKG_HDR  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_FILE_HDR = 3'd1;
  localparam logic [KIND_W-1:0] KIND_CONTENT  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_DIGEST   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_IGNORED  = 3'd4;

  // Status codes.
  localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_SIG    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_PKG_PARITY = 3'd2;
  localparam logic [STATUS_W-1:0] ST_BAD_TYPE   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FILE_LEN   = 3'd4;
  localparam logic [STATUS_W-1:0] ST_DONE       = 3'd5;

  // File type bytes.
  localparam logic [7:0] TYPE_MANIFEST   = 8'h80;
  localparam logic [7:0] TYPE_BOOTLOADER = 8'h81;
  localparam logic [7:0] TYPE_IMAGE      = 8'h82;
  localparam logic [7:0] TYPE_MODULE     = 8'h83;

  // Signature size and last header byte indices; byte 12 is the file count.
  localparam logic [3:0] PKG_SIG_BYTES  = 4'd8;
  localparam logic [3:0] PKG_LAST_BYTE  = 4'd12;
  localparam logic [3:0] FILE_LAST_BYTE = 4'd4;

  localparam logic [7:0] SIGNATURE [8] = '{8'h59, 8'h75, 8'h6E, 8'h4F,
                                           8'h53, 8'h59, 8'h6F, 8'h43};

  typedef struct packed {
    logic [KIND_W-1:0]   byte_kind;
    logic [7:0]          data_out;
    logic [1:0]          file_kind;
    logic [LEN_W-1:0]    file_offset;
    logic                last_of_file;
    logic [LEN_W-1:0]    package_length;
    logic [STATUS_W-1:0] status;
  } result_t;

endpackage

### design/updf_core.sv
// Deframing state and per-byte classification for the update package deframer.
// Builds one result word per accepted byte; depends on updf_pkg.
module updf_core
  import updf_pkg::*;
#(
  parameter int DIGEST_BYTES = DIGEST_BYTES_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  logic [7:0] data_byte,
  input  logic       cfg_wr_en,
  input  logic       cfg_wr_data,
  output result_t    res
);

  typedef enum logic [4:0] {
    PH_PKG    = 5'b00001,
    PH_FHDR   = 5'b00010,
    PH_DATA   = 5'b00100,
    PH_DIGEST = 5'b01000,
    PH_STOP   = 5'b10000
  } phase_t;

  phase_t              phase, phase_next;
  logic [3:0]          header_byte_count, header_byte_count_next;
  logic [31:0]         length_shift, length_shift_next;
  logic [7:0]          files_left, files_left_next;
  logic [1:0]          current_type, current_type_next;
  logic [LEN_W-1:0]    file_length, file_length_next;
  logic [LEN_W-1:0]    content_count, content_count_next;
  logic [STATUS_W-1:0] error_code, error_code_next;
  logic                module_type_enable;

  logic [1:0]  lane;
  logic [31:0] length_merged;
  logic [7:0]  files_dec;
  logic [31:0] count_inc;

  always_comb begin
    phase_next             = phase;
    header_byte_count_next = header_byte_count;
    length_shift_next      = length_shift;
    files_left_next        = files_left;
    current_type_next      = current_type;
    file_length_next       = file_length;
    content_count_next     = content_count;
    error_code_next        = error_code;

    res                = '0;
    res.data_out       = data_byte;
    res.byte_kind      = KIND_IGNORED;

    // Package header length bytes sit at 8..11, file header ones at 1..4.
    lane          = (phase == PH_PKG) ? header_byte_count[1:0]
                                      : 2'(header_byte_count - 4'd1);
    length_merged = length_shift | ({24'b0, data_byte} << {lane, 3'b000});
    files_dec     = 8'(files_left - 8'd1);
    count_inc     = {1'b0, content_count} + 32'd1;

    case (phase)
      PH_PKG: begin
        res.byte_kind = KIND_PKG_HDR;
        if (header_byte_count < PKG_SIG_BYTES) begin
          if (header_byte_count == 4'd0) begin
            length_shift_next = '0;
          end
          if (data_byte != SIGNATURE[header_byte_count[2:0]]) begin
            res.status      = ST_BAD_SIG;
            error_code_next = ST_BAD_SIG;
            phase_next      = PH_STOP;
          end else begin
            header_byte_count_next = header_byte_count + 4'd1;
          end
        end else if (header_byte_count < PKG_LAST_BYTE) begin
          length_shift_next      = length_merged;
          header_byte_count_next = header_byte_count + 4'd1;
        end else if (^length_shift) begin
          res.status      = ST_PKG_PARITY;
          error_code_next = ST_PKG_PARITY;
          phase_next      = PH_STOP;
        end else begin
          res.package_length     = length_shift[31:1];
          files_left_next        = data_byte;
          header_byte_count_next = '0;
          content_count_next     = '0;
          length_shift_next      = '0;
          phase_next             = (data_byte != 8'd0) ? PH_FHDR : PH_DIGEST;
        end
      end
      PH_FHDR: begin
        res.byte_kind = KIND_FILE_HDR;
        if (header_byte_count == 4'd0) begin
          if (data_byte >= TYPE_MANIFEST &&
              (data_byte <= TYPE_IMAGE ||
               (data_byte == TYPE_MODULE && module_type_enable))) begin
            current_type_next      = data_byte[1:0];
            res.file_kind          = data_byte[1:0];
            length_shift_next      = '0;
            header_byte_count_next = 4'd1;
          end else begin
            res.status      = ST_BAD_TYPE;
            error_code_next = ST_BAD_TYPE;
            phase_next      = PH_STOP;
          end
        end else begin
          res.file_kind     = current_type;
          length_shift_next = length_merged;
          if (header_byte_count < FILE_LAST_BYTE) begin
            header_byte_count_next = header_byte_count + 4'd1;
          end else if ((^length_merged) || (length_merged[31:1] == '0)) begin
            res.status      = ST_FILE_LEN;
            error_code_next = ST_FILE_LEN;
            phase_next      = PH_STOP;
          end else begin
            file_length_next       = length_merged[31:1];
            content_count_next     = '0;
            header_byte_count_next = '0;
            phase_next             = PH_DATA;
          end
        end
      end
      PH_DATA: begin
        res.byte_kind   = KIND_CONTENT;
        res.file_kind   = current_type;
        res.file_offset = content_count;
        if (count_inc >= {1'b0, file_length}) begin
          res.last_of_file       = 1'b1;
          files_left_next        = files_dec;
          header_byte_count_next = '0;
          content_count_next     = '0;
          length_shift_next      = '0;
          phase_next             = (files_dec != 8'd0) ? PH_FHDR : PH_DIGEST;
        end else begin
          content_count_next = count_inc[LEN_W-1:0];
        end
      end
      PH_DIGEST: begin
        res.byte_kind = KIND_DIGEST;
        if (count_inc >= 32'(DIGEST_BYTES)) begin
          res.status      = ST_DONE;
          error_code_next = ST_DONE;
          phase_next      = PH_STOP;
        end else begin
          content_count_next = count_inc[LEN_W-1:0];
        end
      end
      default: begin
        res.byte_kind = KIND_IGNORED;
        res.status    = error_code;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase              <= PH_PKG;
      header_byte_count  <= '0;
      length_shift       <= '0;
      files_left         <= '0;
      current_type       <= '0;
      file_length        <= '0;
      content_count      <= '0;
      error_code         <= ST_OK;
      module_type_enable <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        module_type_enable <= cfg_wr_data;
      end
      if (step) begin
        phase             <= phase_next;
        header_byte_count <= header_byte_count_next;
        length_shift      <= length_shift_next;
        files_left        <= files_left_next;
        current_type      <= current_type_next;
        file_length       <= file_length_next;
        content_count     <= content_count_next;
        error_code        <= error_code_next;
      end
    end
  end

`ifndef SYNTH
  // The stopped phase is left only by reset.
  a_stop_sticky: assert property (@(posedge clk) disable iff (rst)
    phase == PH_STOP |=> phase == PH_STOP)
    else $error("updf_core: left the stopped phase");

  // A latched code always goes with the stopped phase.
  a_code_stops: assert property (@(posedge clk) disable iff (rst)
    error_code != ST_OK |-> phase == PH_STOP)
    else $error("updf_core: status latched outside the stopped phase");

  // Finishing a file uses up exactly one entry of the file count.
  a_file_count: assert property (@(posedge clk) disable iff (rst)
    step && phase == PH_DATA && res.last_of_file |=>
      files_left == 8'($past(files_left) - 8'd1))
    else $error("updf_core: file count not decremented at end of file");
`endif

endmodule

### design/updf_outbuf.sv
// Two-entry result buffer: an output register backed by a skid register.
// Decouples the input ready from the output ready; depends on updf_pkg.
module updf_outbuf
  import updf_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  result_t push_data,
  output logic    can_push,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_data
);

  logic    skid_valid;
  result_t skid_data;
  logic    pop;

  assign can_push = !skid_valid;
  assign pop      = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || pop) begin
      // The output register is free: the skid word has priority.
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || pop) begin
      out_data <= skid_valid ? skid_data : push_data;
    end else if (push) begin
      skid_data <= push_data;
    end
  end

`ifndef SYNTH
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("updf_outbuf: skid word held with empty output register");

  a_stall_to_skid: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready && push |=> skid_valid)
    else $error("updf_outbuf: word pushed during a stall was lost");

  a_skid_drains: assert property (@(posedge clk) disable iff (rst)
    skid_valid && out_ready |=> out_valid && !skid_valid)
    else $error("updf_outbuf: skid word not moved forward");
`endif

endmodule

### design/update_package_deframer_top.sv
// Top level of the update package deframer.
// Instantiates updf_core and updf_outbuf; depends on updf_pkg.
//
//   channel  | handshake               | payload
//   ---------+-------------------------+------------------------------------------
//   input    | in_valid / in_ready     | data_byte
//   output   | out_valid / out_ready   | byte_kind data_out file_kind file_offset
//            |                         | last_of_file package_length status
//   config   | cfg_wr_en               | cfg_wr_data (module type enable)
//
// One word is taken per cycle while in_ready is high; its result is registered.
// The classification and the state update are done in the accepting cycle.
// A two-word output buffer keeps input ready independent of output ready:
// input ready falls only while both buffer words are full.
// Synchronous reset returns to the start of a package and clears the enable.
module update_package_deframer_top
  import updf_pkg::*;
#(
  parameter int DIGEST_BYTES = DIGEST_BYTES_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          data_byte,
  input  logic                cfg_wr_en,
  input  logic                cfg_wr_data,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [KIND_W-1:0]   byte_kind,
  output logic [7:0]          data_out,
  output logic [1:0]          file_kind,
  output logic [LEN_W-1:0]    file_offset,
  output logic                last_of_file,
  output logic [LEN_W-1:0]    package_length,
  output logic [STATUS_W-1:0] status
);

  logic    step;
  result_t res;
  result_t out_data;

  assign step = in_valid && in_ready;

  updf_core #(
    .DIGEST_BYTES(DIGEST_BYTES)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .data_byte  (data_byte),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .res        (res)
  );

  updf_outbuf u_outbuf (
    .clk      (clk),
    .rst      (rst),
    .push     (step),
    .push_data(res),
    .can_push (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  assign byte_kind      = out_data.byte_kind;
  assign data_out       = out_data.data_out;
  assign file_kind      = out_data.file_kind;
  assign file_offset    = out_data.file_offset;
  assign last_of_file   = out_data.last_of_file;
  assign package_length = out_data.package_length;
  assign status         = out_data.status;

endmodule
